[sv/sip_pkg.sv]
package sip_pkg;

    localparam int COORD_BITS = 16;
    // datapath uses at most 19 coordinate bits
    localparam int DW    = (COORD_BITS > 19) ? 19 : COORD_BITS;
    localparam int DIFW  = DW + 1;
    localparam int PRODW = 2 * DIFW;
    localparam int DEMW  = PRODW + 1;
    localparam int MAGW  = PRODW;
    localparam int LOW   = MAGW / 2;
    localparam int HIW   = MAGW - LOW;
    localparam int NW    = MAGW + DIFW;
    localparam int QW    = DIFW + 1;
    localparam int RW    = NW + 2;
    localparam int D2W   = MAGW + 1;
    localparam int SW    = COORD_BITS + QW;

    localparam int QDEPTH = 8;
    localparam int QAW    = 3;

    typedef enum logic [1:0] {
        ST_NO_CROSS = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_CROSS    = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_in;

    typedef struct packed {
        t_status                      cross_status;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_out;

    typedef struct packed {
        t_status              st;
        logic signed [DEMW-1:0] an;
        logic signed [DEMW-1:0] dem;
        logic signed [DIFW-1:0] ax;
        logic signed [DIFW-1:0] ay;
        logic signed [DW-1:0]   sx;
        logic signed [DW-1:0]   sy;
    } t_cls;

endpackage

[sv/sip_front.sv]
module sip_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sip_pkg::t_in  i_item,
    output logic          o_valid,
    output sip_pkg::t_cls o_cls
);
    import sip_pkg::*;

    function automatic logic signed [DIFW-1:0] ext(input logic signed [DW-1:0] v);
        ext = {v[DW-1], v};
    endfunction

    function automatic logic box_rej(input logic signed [DW-1:0] s1, input logic signed [DW-1:0] e1,
                                     input logic signed [DW-1:0] s2, input logic signed [DW-1:0] e2);
        logic signed [DIFW-1:0] a;
        logic signed [DIFW-1:0] b;
        a = ext(e1) - ext(s1);
        b = ext(s2) - ext(e2);
        if (a > 0) begin
            if (b > 0) box_rej = (e1 < e2) || (s2 < s1);
            else       box_rej = (e1 < s2) || (e2 < s1);
        end else begin
            if (b > 0) box_rej = (s1 < e2) || (s2 < e1);
            else       box_rej = (s1 < s2) || (e2 < e1);
        end
    endfunction

    function automatic logic in_rng(input logic signed [DEMW-1:0] n,
                                    input logic signed [DEMW-1:0] d);
        if (d > 0) in_rng = !(n < 0 || n > d);
        else       in_rng = !(n > 0 || n < d);
    endfunction

    logic signed [DW-1:0] sx, sy, ex, ey, tx, ty, ux, uy;
    assign sx = i_item.first_start_x[DW-1:0];
    assign sy = i_item.first_start_y[DW-1:0];
    assign ex = i_item.first_end_x[DW-1:0];
    assign ey = i_item.first_end_y[DW-1:0];
    assign tx = i_item.second_start_x[DW-1:0];
    assign ty = i_item.second_start_y[DW-1:0];
    assign ux = i_item.second_end_x[DW-1:0];
    assign uy = i_item.second_end_y[DW-1:0];

    // stage A: box test and direction vectors
    logic                   r_a_v, r_a_rej;
    logic signed [DIFW-1:0] r_a_ax, r_a_ay, r_a_bx, r_a_by, r_a_cx, r_a_cy;
    logic signed [DW-1:0]   r_a_sx, r_a_sy;

    // stage B: cross products
    logic                    r_b_v, r_b_rej;
    logic signed [PRODW-1:0] r_b_aybx, r_b_axby, r_b_bycx, r_b_bxcy, r_b_axcy, r_b_aycx;
    logic signed [DIFW-1:0]  r_b_ax, r_b_ay;
    logic signed [DW-1:0]    r_b_sx, r_b_sy;

    // stage C: determinant, numerators, classification
    logic                   r_c_v;
    t_cls                   r_c;
    logic signed [DEMW-1:0] dem, an, bn;
    t_status                st;

    always_comb begin
        dem = DEMW'(r_b_aybx) - DEMW'(r_b_axby);
        an  = DEMW'(r_b_bycx) - DEMW'(r_b_bxcy);
        bn  = DEMW'(r_b_axcy) - DEMW'(r_b_aycx);
        priority if (r_b_rej)                      st = ST_NO_CROSS;
        else if (dem == '0)                        st = ST_PARALLEL;
        else if (in_rng(an, dem) && in_rng(bn, dem)) st = ST_CROSS;
        else                                       st = ST_NO_CROSS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
        r_a_rej <= box_rej(sx, ex, tx, ux) || box_rej(sy, ey, ty, uy);
        r_a_ax  <= ext(ex) - ext(sx);
        r_a_ay  <= ext(ey) - ext(sy);
        r_a_bx  <= ext(tx) - ext(ux);
        r_a_by  <= ext(ty) - ext(uy);
        r_a_cx  <= ext(sx) - ext(tx);
        r_a_cy  <= ext(sy) - ext(ty);
        r_a_sx  <= sx;
        r_a_sy  <= sy;

        r_b_rej  <= r_a_rej;
        r_b_aybx <= r_a_ay * r_a_bx;
        r_b_axby <= r_a_ax * r_a_by;
        r_b_bycx <= r_a_by * r_a_cx;
        r_b_bxcy <= r_a_bx * r_a_cy;
        r_b_axcy <= r_a_ax * r_a_cy;
        r_b_aycx <= r_a_ay * r_a_cx;
        r_b_ax   <= r_a_ax;
        r_b_ay   <= r_a_ay;
        r_b_sx   <= r_a_sx;
        r_b_sy   <= r_a_sy;

        r_c.st  <= st;
        r_c.an  <= an;
        r_c.dem <= dem;
        r_c.ax  <= r_b_ax;
        r_c.ay  <= r_b_ay;
        r_c.sx  <= r_b_sx;
        r_c.sy  <= r_b_sy;
    end

    assign o_valid = r_c_v;
    assign o_cls   = r_c;

endmodule

[sv/sip_queue.sv]
module sip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sip_pkg::t_cls i_cls,
    input  logic          i_pop,
    output logic          o_empty,
    output sip_pkg::t_cls o_cls
);
    import sip_pkg::*;

    t_cls           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_cls;
    end

    assign o_empty = (r_cnt == '0);
    assign o_cls   = r_mem[r_rd];

endmodule

[sv/sip_back.sv]
module sip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sip_pkg::t_cls i_cls,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output sip_pkg::t_out o_item
);
    import sip_pkg::*;

    logic r_ov;
    logic en;
    assign en      = !r_ov || i_pop;
    assign o_q_pop = en && !i_q_empty;

    // S0: magnitudes and signs
    logic                 r0_v, r0_nx, r0_ny;
    t_status              r0_st;
    logic [MAGW-1:0]      r0_an, r0_d;
    logic [DIFW-1:0]      r0_ax, r0_ay;
    logic signed [DW-1:0] r0_sx, r0_sy;
    logic [DEMW-1:0]      an_abs, dem_abs;
    logic [DIFW-1:0]      ax_abs, ay_abs;

    always_comb begin
        an_abs  = i_cls.an[DEMW-1]  ? -i_cls.an  : i_cls.an;
        dem_abs = i_cls.dem[DEMW-1] ? -i_cls.dem : i_cls.dem;
        ax_abs  = i_cls.ax[DIFW-1]  ? -i_cls.ax  : i_cls.ax;
        ay_abs  = i_cls.ay[DIFW-1]  ? -i_cls.ay  : i_cls.ay;
    end

    // S1: partial products
    logic                    r1_v, r1_nx, r1_ny;
    t_status                 r1_st;
    logic [LOW+DIFW-1:0]     r1_lx, r1_ly;
    logic [HIW+DIFW-1:0]     r1_hx, r1_hy;
    logic [MAGW-1:0]         r1_d;
    logic signed [DW-1:0]    r1_sx, r1_sy;

    // divider stages, index 0 loaded from S1
    logic                 r_dv  [QW+1];
    t_status              r_dst [QW+1];
    logic                 r_dnx [QW+1];
    logic                 r_dny [QW+1];
    logic [RW-1:0]        r_rx  [QW+1];
    logic [RW-1:0]        r_ry  [QW+1];
    logic [QW-1:0]        r_qx  [QW+1];
    logic [QW-1:0]        r_qy  [QW+1];
    logic [D2W-1:0]       r_d2  [QW+1];
    logic signed [DW-1:0] r_dsx [QW+1];
    logic signed [DW-1:0] r_dsy [QW+1];

    logic [NW-1:0] nx, ny;
    assign nx = (NW'(r1_hx) << LOW) + NW'(r1_lx);
    assign ny = (NW'(r1_hy) << LOW) + NW'(r1_ly);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v     <= 1'b0;
            r1_v     <= 1'b0;
            r_dv[0]  <= 1'b0;
        end else if (en) begin
            r0_v    <= o_q_pop;
            r1_v    <= r0_v;
            r_dv[0] <= r1_v;
        end
        if (en) begin
            r0_st <= i_cls.st;
            r0_an <= an_abs[MAGW-1:0];
            r0_d  <= dem_abs[MAGW-1:0];
            r0_ax <= ax_abs;
            r0_ay <= ay_abs;
            r0_nx <= i_cls.ax[DIFW-1] ^ i_cls.an[DEMW-1] ^ i_cls.dem[DEMW-1];
            r0_ny <= i_cls.ay[DIFW-1] ^ i_cls.an[DEMW-1] ^ i_cls.dem[DEMW-1];
            r0_sx <= i_cls.sx;
            r0_sy <= i_cls.sy;

            r1_st <= r0_st;
            r1_lx <= r0_an[LOW-1:0] * r0_ax;
            r1_hx <= r0_an[MAGW-1:LOW] * r0_ax;
            r1_ly <= r0_an[LOW-1:0] * r0_ay;
            r1_hy <= r0_an[MAGW-1:LOW] * r0_ay;
            r1_d  <= r0_d;
            r1_nx <= r0_nx;
            r1_ny <= r0_ny;
            r1_sx <= r0_sx;
            r1_sy <= r0_sy;

            // round half away: floor((2n + d) / 2d)
            r_dst[0] <= r1_st;
            r_dnx[0] <= r1_nx;
            r_dny[0] <= r1_ny;
            r_rx[0]  <= (RW'(nx) << 1) + RW'(r1_d);
            r_ry[0]  <= (RW'(ny) << 1) + RW'(r1_d);
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            r_d2[0]  <= {r1_d, 1'b0};
            r_dsx[0] <= r1_sx;
            r_dsy[0] <= r1_sy;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [RW-1:0] sh;
        logic          gx, gy;
        assign sh = RW'(r_d2[k]) << B;
        assign gx = (r_rx[k] >= sh);
        assign gy = (r_ry[k] >= sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_rx[k+1]    <= gx ? r_rx[k] - sh : r_rx[k];
                r_ry[k+1]    <= gy ? r_ry[k] - sh : r_ry[k];
                r_qx[k+1]    <= r_qx[k] | (QW'(gx) << B);
                r_qy[k+1]    <= r_qy[k] | (QW'(gy) << B);
                r_d2[k+1]    <= r_d2[k];
                r_dst[k+1]   <= r_dst[k];
                r_dnx[k+1]   <= r_dnx[k];
                r_dny[k+1]   <= r_dny[k];
                r_dsx[k+1]   <= r_dsx[k];
                r_dsy[k+1]   <= r_dsy[k];
            end
        end
    end

    // output register
    logic signed [SW-1:0] qx, qy, px, py;
    t_out                 r_o;

    always_comb begin
        qx = SW'(r_qx[QW]);
        qy = SW'(r_qy[QW]);
        px = SW'(r_dsx[QW]) + (r_dnx[QW] ? -qx : qx);
        py = SW'(r_dsy[QW]) + (r_dny[QW] ? -qy : qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QW];
        end
        if (en) begin
            r_o.cross_status <= r_dst[QW];
            if (r_dst[QW] == ST_CROSS) begin
                r_o.point_x <= px[COORD_BITS-1:0];
                r_o.point_y <= py[COORD_BITS-1:0];
            end else begin
                r_o.point_x <= '0;
                r_o.point_y <= '0;
            end
        end
    end

    assign o_empty = !r_ov;
    assign o_item  = r_o;

endmodule

[sv/segment_intersection_point_top.sv]
// Segment intersection point.
// Input channel: drive i_item with two segments and raise i_push; the
// transaction completes on a clock edge with i_push high and o_full low.
// Result channel: while o_empty is low, o_item holds the oldest result
// (status, and the rounded crossing point, zero unless the segments cross);
// raise i_pop to take it.
// Throughput: one transaction per cycle in each direction, while o_full is
// low and the receiver keeps i_pop high. A result passes through a
// three-stage classify pipeline, one queue slot, a magnitude stage, a
// multiply stage, a divider load stage, the 18-stage restoring divider
// (one stage per quotient bit) and the output register.
// The classify front feeds an eight-entry queue by credit; o_full rises
// when eight transactions sit in the front pipeline and the queue.
// When the receiver stalls, the back pipeline holds behind the output
// register and the front keeps filling the queue.
// Reset (synchronous, active low) drops everything in flight and empties
// the queue; there is no other state.
module segment_intersection_point_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sip_pkg::t_in  i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output sip_pkg::t_out o_item
);
    import sip_pkg::*;

    logic         f_valid, q_empty, q_pop, acc;
    t_cls         f_cls, q_cls;
    logic [QAW:0] r_cred;

    assign acc    = i_push && !o_full;
    assign o_full = (r_cred == (QAW+1)'(QDEPTH));

    // credits cover the front pipeline plus the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            r_cred <= r_cred + (QAW+1)'(acc) - (QAW+1)'(q_pop);
        end
    end

    sip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_cls   (f_cls)
    );

    sip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_cls   (f_cls),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cls   (q_cls)
    );

    sip_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cls     (q_cls),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_item    (o_item)
    );

endmodule
